// ----- design/ps2ksd_pkg.sv -----
package ps2ksd_pkg;

    localparam int PAT_CAP = 16;
    localparam int MASK_W  = 11;
    localparam int COUNT_W = 8;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] SC_EXTEND = 8'hE0;
    localparam logic [7:0] SC_BREAK  = 8'hF0;

    typedef struct packed {
        logic       kind;
        logic [7:0] scan_byte;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0]  matched_mask;
        logic [COUNT_W-1:0] new_press_count;
    } result_t;

    // one walk step or tick clear towards the pattern matcher
    typedef struct packed {
        logic       clr;
        logic       press;
        logic [7:0] slot;
    } match_ctl_t;

    // set-2 scancode to key slot, unmapped codes land on slot 0
    function automatic logic [6:0] scan_slot(input logic [7:0] code);
        logic [6:0] s;
        case (code)
            8'h03: s = 7'd9;    8'h0D: s = 7'd9;    8'h0E: s = 7'd96;
            8'h12: s = 7'd5;    8'h14: s = 7'd6;    8'h15: s = 7'd113;
            8'h16: s = 7'd49;   8'h1A: s = 7'd122;  8'h1B: s = 7'd115;
            8'h1C: s = 7'd97;   8'h1D: s = 7'd119;  8'h1E: s = 7'd50;
            8'h21: s = 7'd99;   8'h22: s = 7'd120;  8'h23: s = 7'd100;
            8'h24: s = 7'd101;  8'h25: s = 7'd52;   8'h26: s = 7'd51;
            8'h29: s = 7'd32;   8'h2A: s = 7'd118;  8'h2B: s = 7'd102;
            8'h2C: s = 7'd116;  8'h2D: s = 7'd114;  8'h2E: s = 7'd53;
            8'h31: s = 7'd110;  8'h32: s = 7'd98;   8'h33: s = 7'd104;
            8'h34: s = 7'd103;  8'h35: s = 7'd121;  8'h36: s = 7'd54;
            8'h3A: s = 7'd109;  8'h3B: s = 7'd106;  8'h3C: s = 7'd117;
            8'h3D: s = 7'd55;   8'h3E: s = 7'd56;   8'h41: s = 7'd44;
            8'h42: s = 7'd107;  8'h43: s = 7'd105;  8'h44: s = 7'd111;
            8'h45: s = 7'd48;   8'h46: s = 7'd57;   8'h49: s = 7'd46;
            8'h4A: s = 7'd47;   8'h4B: s = 7'd108;  8'h4C: s = 7'd59;
            8'h4D: s = 7'd112;  8'h4E: s = 7'd45;   8'h52: s = 7'd39;
            8'h54: s = 7'd91;   8'h55: s = 7'd61;   8'h5B: s = 7'd93;
            8'h5D: s = 7'd92;   8'h6B: s = 7'd2;    8'h72: s = 7'd3;
            8'h74: s = 7'd4;    8'h75: s = 7'd1;    8'h76: s = 7'd7;
            8'h91: s = 7'd8;
            default: s = 7'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] pat_len(input logic [3:0] p);
        logic [3:0] n;
        case (p)
            4'd0:  n = 4'd11;
            4'd1:  n = 4'd6;
            4'd2:  n = 4'd3;
            4'd3:  n = 4'd3;
            4'd4:  n = 4'd4;
            4'd5:  n = 4'd5;
            4'd6:  n = 4'd6;
            4'd7:  n = 4'd6;
            4'd8:  n = 4'd10;
            4'd9:  n = 4'd5;
            4'd10: n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // text right-justified: first character in the highest used byte
    function automatic logic [127:0] pat_row(input logic [3:0] p);
        logic [127:0] row;
        case (p)
            4'd0:  row = "musfreelook";
            4'd1:  row = "mushud";
            4'd2:  row = "uwu";
            4'd3:  row = "rey";
            4'd4:  row = "test";
            4'd5:  row = "idkfa";
            4'd6:  row = "musfps";
            4'd7:  row = "idclip";
            4'd8:  row = "idspispopd";
            4'd9:  row = "iddqd";
            4'd10: row = 128'h09;
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] pat_char(input logic [3:0] p, input logic [3:0] g);
        logic [127:0] row;
        logic [3:0]   idx;
        row = pat_row(p);
        idx = pat_len(p) - 4'd1 - g;
        return row[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ----- design/ps2_key_sequence_detector_top.sv -----
// scancode byte: the block stays idle and ready for the next item, no result
// frame tick: a key walk, then the emit state loads the result; the key walk reads
// one slot a cycle from the held and previous key memories
// next item is taken the cycle after the result is loaded, while it waits downstream
// after reset a clearing pass writes zero to every slot of both key memories, no item
// is taken during it; pattern progress, release flag and result valid reset at once
module ps2_key_sequence_detector_top #(
    parameter int KEY_SLOTS       = 128,
    parameter int NUM_PATTERNS    = 11,
    parameter int MAX_PATTERN_LEN = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  ps2ksd_pkg::item_t     item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ps2ksd_pkg::result_t   result
);

    localparam int SLOT_W  = $clog2(KEY_SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int COUNT_W = ps2ksd_pkg::COUNT_W;
    localparam int MASK_W  = ps2ksd_pkg::MASK_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic                 armed_reg, armed_next;
    logic [COUNT_W-1:0]   press_cnt_reg, press_cnt_next;
    logic                 result_valid_reg, result_valid_next;
    ps2ksd_pkg::result_t  result_reg, result_next;

    logic                 held_mem [KEY_SLOTS];
    logic                 prev_mem [KEY_SLOTS];
    logic                 held_q;
    logic                 prev_q;

    logic                 held_we, held_wdata;
    logic [SLOT_W-1:0]    held_waddr;
    logic                 prev_we, prev_wdata;
    logic [SLOT_W-1:0]    prev_waddr;

    logic                 item_acc;
    logic                 rd_en;
    logic                 press;
    logic [6:0]           rom_slot;
    ps2ksd_pkg::match_ctl_t mctl;
    logic [MASK_W-1:0]    mask;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign rom_slot   = ps2ksd_pkg::scan_slot(item.scan_byte);
    assign rd_en      = (state_reg == ST_WALK) && (cnt_reg < CNT_W'(KEY_SLOTS));
    assign press      = rd_valid_reg && held_q && !prev_q;

    assign mctl.clr   = item_acc && (item.kind == ps2ksd_pkg::KIND_TICK);
    assign mctl.press = press;
    assign mctl.slot  = 8'(rd_slot_reg);

    ps2ksd_match #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .mask  (mask)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        rd_valid_next     = 1'b0;
        rd_slot_next      = rd_slot_reg;
        armed_next        = armed_reg;
        press_cnt_next    = press_cnt_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        held_we           = 1'b0;
        held_waddr        = SLOT_W'(rom_slot);
        held_wdata        = !armed_reg;
        prev_we           = 1'b0;
        prev_waddr        = rd_slot_reg;
        prev_wdata        = held_q;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                held_we    = 1'b1;
                held_waddr = cnt_reg[SLOT_W-1:0];
                held_wdata = 1'b0;
                prev_we    = 1'b1;
                prev_waddr = cnt_reg[SLOT_W-1:0];
                prev_wdata = 1'b0;
                if (cnt_reg == CNT_W'(KEY_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.kind == ps2ksd_pkg::KIND_TICK)
                    begin
                        // release flag is dropped by the tick, no byte can arrive mid-walk
                        armed_next     = 1'b0;
                        cnt_next       = '0;
                        press_cnt_next = '0;
                        state_next     = ST_WALK;
                    end
                    else if (item.scan_byte == ps2ksd_pkg::SC_BREAK)
                    begin
                        armed_next = 1'b1;
                    end
                    else if (item.scan_byte != ps2ksd_pkg::SC_EXTEND)
                    begin
                        held_we    = 1'b1;
                        armed_next = 1'b0;
                    end
                end
            end
            ST_WALK:
            begin
                if (rd_en)
                begin
                    rd_valid_next = 1'b1;
                    rd_slot_next  = cnt_reg[SLOT_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
                // previous bit takes the held bit of the slot read last cycle
                prev_we = rd_valid_reg;
                if (press)
                begin
                    press_cnt_next = press_cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next           = 1'b1;
                    result_next.matched_mask    = mask;
                    result_next.new_press_count = press_cnt_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_waddr] <= held_wdata;
        end
        if (rd_en)
        begin
            held_q <= held_mem[cnt_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en)
        begin
            prev_q <= prev_mem[cnt_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            armed_reg        <= 1'b0;
            press_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            rd_valid_reg     <= rd_valid_next;
            armed_reg        <= armed_next;
            press_cnt_reg    <= press_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> cnt_reg <= CNT_W'(KEY_SLOTS))
        else $error("key walk ran past the last slot");

    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && item.kind == ps2ksd_pkg::KIND_TICK
        |=> state_reg == ST_WALK && cnt_reg == '0 && press_cnt_reg == '0)
        else $error("tick did not start a fresh walk");

    a_prev_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> state_reg == ST_WALK)
        else $error("slot read data pending outside the walk");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised without a finished walk");

endmodule

// ----- design/ps2ksd_match.sv -----
module ps2ksd_match #(
    parameter int NUM_PATTERNS    = 11,
    parameter int MAX_PATTERN_LEN = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ps2ksd_pkg::match_ctl_t            ctl,
    output logic [ps2ksd_pkg::MASK_W-1:0]     mask
);

    localparam int         PAT_CAP = ps2ksd_pkg::PAT_CAP;
    localparam int         MASK_W  = ps2ksd_pkg::MASK_W;
    localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN_LEN);

    logic [NUM_PATTERNS-1:0] hit_vec;
    logic [PAT_CAP-1:0]      hit_wide;
    logic [MASK_W-1:0]       mask_reg;
    logic [MASK_W-1:0]       mask_next;

    for (genvar gp = 0; gp < NUM_PATTERNS; gp++) begin : g_lane
        logic [3:0] len;
        logic [3:0] prog_reg;
        logic [3:0] prog_next;
        logic       hit;

        always_comb
        begin
            len = ps2ksd_pkg::pat_len(4'(gp));
            if (len > MAX_LEN)
            begin
                len = MAX_LEN;
            end
            prog_next = prog_reg;
            hit       = 1'b0;
            if (ctl.press)
            begin
                if (len == 4'd0)
                begin
                    prog_next = 4'd0;
                end
                else
                begin
                    if (prog_reg < len &&
                        ps2ksd_pkg::pat_char(4'(gp), prog_reg) == ctl.slot)
                    begin
                        prog_next = prog_reg + 4'd1;
                    end
                    else
                    begin
                        prog_next = 4'd0;
                    end
                    if (prog_next >= len)
                    begin
                        prog_next = 4'd0;
                        hit       = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prog_reg <= 4'd0;
            end
            else
            begin
                prog_reg <= prog_next;
            end
        end

        assign hit_vec[gp] = hit;
    end

    always_comb
    begin
        hit_wide = '0;
        hit_wide[NUM_PATTERNS-1:0] = hit_vec;
        if (ctl.clr)
        begin
            mask_next = '0;
        end
        else
        begin
            mask_next = mask_reg | hit_wide[MASK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign mask = mask_reg;

endmodule
